### src/socks_request_parser_assert.svh
// Assertion macros for the SOCKS request parser.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef SOCKS_REQUEST_PARSER_ASSERT_SVH
`define SOCKS_REQUEST_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRP_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/srp_pkg.sv
// Package for the SOCKS request parser: phase, event, error and address codes,
// parse-state and result types. No dependencies.
`default_nettype none

package srp_pkg;

    localparam int DataW  = 8;
    localparam int TdataW = 80;
    localparam int TuserW = 3;

    localparam logic [3:0] PH_VER      = 4'd0;
    localparam logic [3:0] PH_S4_FIX   = 4'd1;
    localparam logic [3:0] PH_S4_USER  = 4'd2;
    localparam logic [3:0] PH_S4_HOST  = 4'd3;
    localparam logic [3:0] PH_S5_NMETH = 4'd4;
    localparam logic [3:0] PH_S5_METH  = 4'd5;
    localparam logic [3:0] PH_S5_RVER  = 4'd6;
    localparam logic [3:0] PH_S5_RCMD  = 4'd7;
    localparam logic [3:0] PH_S5_RSV   = 4'd8;
    localparam logic [3:0] PH_S5_ATYP  = 4'd9;
    localparam logic [3:0] PH_S5_IPV4  = 4'd10;
    localparam logic [3:0] PH_S5_DLEN  = 4'd11;
    localparam logic [3:0] PH_S5_NAME  = 4'd12;
    localparam logic [3:0] PH_S5_PORT  = 4'd13;
    localparam logic [3:0] PH_HALT     = 4'd14;
    localparam logic [3:0] PH_UNUSED   = 4'd15;

    localparam logic [2:0] EV_CONT   = 3'd0;
    localparam logic [2:0] EV_METHOD = 3'd1;
    localparam logic [2:0] EV_READY  = 3'd2;
    localparam logic [2:0] EV_ERROR  = 3'd3;
    localparam logic [2:0] EV_NAME   = 3'd4;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_VERSION = 3'd1;
    localparam logic [2:0] ERR_BAD_ATYP    = 3'd2;
    localparam logic [2:0] ERR_NOT_CONNECT = 3'd3;
    localparam logic [2:0] ERR_NO_METHODS  = 3'd4;
    localparam logic [2:0] ERR_NO_ACCEPT   = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd6;

    localparam logic [1:0] AT_NONE = 2'd0;
    localparam logic [1:0] AT_IPV4 = 2'd1;
    localparam logic [1:0] AT_NAME = 2'd2;
    localparam logic [1:0] AT_IPV6 = 2'd3;

    localparam logic [7:0] VER_SOCKS4   = 8'd4;
    localparam logic [7:0] VER_SOCKS5   = 8'd5;
    localparam logic [7:0] CMD_CONNECT  = 8'd1;
    localparam logic [7:0] ATYP_IPV4    = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN  = 8'd3;
    localparam logic [7:0] ATYP_IPV6    = 8'd4;
    localparam logic [7:0] METHOD_NOAUTH = 8'h00;
    localparam logic [7:0] METHOD_NONE   = 8'hFF;
    localparam logic [7:0] MAX_LEN_RESET = 8'd255;

    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  proto_version;
        logic [7:0]  command_code;
        logic [1:0]  address_type;
        logic [15:0] port_val;
        logic [31:0] ipv4_val;
        logic [7:0]  bytes_left;
        logic        method_found;
    } srp_state_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  error_code;
        logic [2:0]  version;
        logic [7:0]  command;
        logic [1:0]  address_kind;
        logic [15:0] dest_port;
        logic [31:0] dest_ipv4;
        logic [7:0]  selected_method;
        logic [7:0]  name_byte;
        logic        name_last;
    } srp_result_t;

endpackage

`default_nettype wire

### src/srp_step.sv
// One parse step of the SOCKS request parser: next parse state and result beat.
// Depends on srp_pkg.
`default_nettype none

module srp_step (
    input  srp_pkg::srp_state_t  state_cur,
    input  logic [7:0]           data_byte,
    input  logic                 connection_start,
    input  logic [7:0]           max_string_length,
    output srp_pkg::srp_state_t  state_next,
    output srp_pkg::srp_result_t result
);
    import srp_pkg::*;

    always_comb
    begin
        srp_state_t cur;
        srp_state_t nxt;
        logic [2:0] ev;
        logic [2:0] err;
        logic [7:0] nbyte;
        logic       nlast;
        logic [2:0] pos;

        cur = state_cur;
        if (connection_start)
        begin
            cur = '0;
            cur.phase = PH_VER;
        end
        nxt   = cur;
        ev    = EV_CONT;
        err   = ERR_NONE;
        nbyte = 8'd0;
        nlast = 1'b0;
        pos   = 3'd7 - cur.bytes_left[2:0];

        case (cur.phase)
            PH_VER:
            begin
                if (data_byte == VER_SOCKS4)
                begin
                    nxt.proto_version = 3'd4;
                    nxt.bytes_left    = 8'd7;
                    nxt.phase         = PH_S4_FIX;
                end
                else if (data_byte == VER_SOCKS5)
                begin
                    nxt.proto_version = 3'd5;
                    nxt.phase         = PH_S5_NMETH;
                end
                else
                begin
                    ev = EV_ERROR;
                    err = ERR_BAD_VERSION;
                    nxt.phase = PH_HALT;
                end
            end
            PH_S4_FIX:
            begin
                if (pos == 3'd0)
                    nxt.command_code = data_byte;
                else if (pos <= 3'd2)
                    nxt.port_val = {cur.port_val[7:0], data_byte};
                else
                    nxt.ipv4_val = {cur.ipv4_val[23:0], data_byte};
                nxt.bytes_left = cur.bytes_left - 8'd1;
                if (nxt.bytes_left == 8'd0)
                begin
                    nxt.address_type = (nxt.ipv4_val[31:8] == 24'd0 &&
                                        nxt.ipv4_val[7:0] != 8'd0) ? AT_NAME : AT_IPV4;
                    nxt.phase = PH_S4_USER;
                end
            end
            PH_S4_USER:
            begin
                if (data_byte == 8'd0)
                begin
                    if (cur.address_type == AT_NAME)
                    begin
                        nxt.bytes_left = 8'd0;
                        nxt.phase = PH_S4_HOST;
                    end
                    else
                    begin
                        nxt.phase = PH_HALT;
                        if (cur.command_code != CMD_CONNECT)
                        begin
                            ev = EV_ERROR;
                            err = ERR_NOT_CONNECT;
                        end
                        else
                            ev = EV_READY;
                    end
                end
                else if (cur.bytes_left >= max_string_length)
                begin
                    ev = EV_ERROR;
                    err = ERR_TOO_LONG;
                    nxt.phase = PH_HALT;
                end
                else
                    nxt.bytes_left = cur.bytes_left + 8'd1;
            end
            PH_S4_HOST:
            begin
                if (data_byte == 8'd0)
                begin
                    nxt.phase = PH_HALT;
                    if (cur.command_code != CMD_CONNECT)
                    begin
                        ev = EV_ERROR;
                        err = ERR_NOT_CONNECT;
                    end
                    else
                        ev = EV_READY;
                end
                else if (cur.bytes_left >= max_string_length)
                begin
                    ev = EV_ERROR;
                    err = ERR_TOO_LONG;
                    nxt.phase = PH_HALT;
                end
                else
                begin
                    nxt.bytes_left = cur.bytes_left + 8'd1;
                    ev = EV_NAME;
                    nbyte = data_byte;
                end
            end
            PH_S5_NMETH:
            begin
                if (data_byte == 8'd0)
                begin
                    ev = EV_ERROR;
                    err = ERR_NO_METHODS;
                    nxt.phase = PH_HALT;
                end
                else
                begin
                    nxt.bytes_left   = data_byte;
                    nxt.method_found = 1'b0;
                    nxt.phase        = PH_S5_METH;
                end
            end
            PH_S5_METH:
            begin
                if (data_byte == METHOD_NOAUTH)
                    nxt.method_found = 1'b1;
                nxt.bytes_left = cur.bytes_left - 8'd1;
                if (nxt.bytes_left == 8'd0)
                begin
                    ev = EV_METHOD;
                    if (nxt.method_found)
                        nxt.phase = PH_S5_RVER;
                    else
                    begin
                        err = ERR_NO_ACCEPT;
                        nxt.phase = PH_HALT;
                    end
                end
            end
            PH_S5_RVER:
                nxt.phase = PH_S5_RCMD;
            PH_S5_RCMD:
            begin
                nxt.command_code = data_byte;
                nxt.phase = PH_S5_RSV;
            end
            PH_S5_RSV:
                nxt.phase = PH_S5_ATYP;
            PH_S5_ATYP:
            begin
                if (data_byte == ATYP_IPV4)
                begin
                    nxt.address_type = AT_IPV4;
                    nxt.bytes_left = 8'd4;
                    nxt.phase = PH_S5_IPV4;
                end
                else if (data_byte == ATYP_DOMAIN)
                begin
                    nxt.address_type = AT_NAME;
                    nxt.phase = PH_S5_DLEN;
                end
                else if (data_byte == ATYP_IPV6)
                begin
                    nxt.address_type = AT_IPV6;
                    nxt.bytes_left = 8'd16;
                    nxt.phase = PH_S5_NAME;
                end
                else
                begin
                    ev = EV_ERROR;
                    err = ERR_BAD_ATYP;
                    nxt.phase = PH_HALT;
                end
            end
            PH_S5_IPV4:
            begin
                nxt.ipv4_val = {cur.ipv4_val[23:0], data_byte};
                nxt.bytes_left = cur.bytes_left - 8'd1;
                if (nxt.bytes_left == 8'd0)
                begin
                    nxt.bytes_left = 8'd2;
                    nxt.phase = PH_S5_PORT;
                end
            end
            PH_S5_DLEN:
            begin
                if (data_byte == 8'd0)
                begin
                    nxt.bytes_left = 8'd2;
                    nxt.phase = PH_S5_PORT;
                end
                else
                begin
                    nxt.bytes_left = data_byte;
                    nxt.phase = PH_S5_NAME;
                end
            end
            PH_S5_NAME:
            begin
                ev = EV_NAME;
                nbyte = data_byte;
                nxt.bytes_left = cur.bytes_left - 8'd1;
                if (nxt.bytes_left == 8'd0)
                begin
                    nlast = 1'b1;
                    nxt.bytes_left = 8'd2;
                    nxt.phase = PH_S5_PORT;
                end
            end
            PH_S5_PORT:
            begin
                nxt.port_val = {cur.port_val[7:0], data_byte};
                nxt.bytes_left = cur.bytes_left - 8'd1;
                if (nxt.bytes_left == 8'd0)
                begin
                    nxt.phase = PH_HALT;
                    if (cur.command_code != CMD_CONNECT)
                    begin
                        ev = EV_ERROR;
                        err = ERR_NOT_CONNECT;
                    end
                    else
                        ev = EV_READY;
                end
            end
            default:
                nxt.phase = PH_HALT;
        endcase

        state_next             = nxt;
        result.event_res       = ev;
        result.error_code      = err;
        result.version         = nxt.proto_version;
        result.command         = nxt.command_code;
        result.address_kind    = nxt.address_type;
        result.dest_port       = nxt.port_val;
        result.dest_ipv4       = nxt.ipv4_val;
        result.selected_method = nxt.method_found ? METHOD_NOAUTH : METHOD_NONE;
        result.name_byte       = nbyte;
        result.name_last       = nlast;
    end

endmodule

`default_nettype wire

### src/srp_out_stage.sv
// Result register of the SOCKS request parser: holds one beat for the master side.
// Depends on srp_pkg.
`default_nettype none

module srp_out_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  srp_pkg::srp_result_t       result,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // error_code[2:0], version[5:3], command[13:6], address_kind[15:14],
    // dest_port[31:16], dest_ipv4[63:32], selected_method[71:64], name_byte[79:72]
    output logic [srp_pkg::TdataW-1:0] m_tdata,
    // event_res[2:0]
    output logic [srp_pkg::TuserW-1:0] m_tuser,
    // name_last
    output logic                       m_tlast
);
    import srp_pkg::*;

    logic        out_valid_reg;
    srp_result_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.event_res;
    assign m_tlast  = out_data_reg.name_last;
    assign m_tdata  = {out_data_reg.name_byte, out_data_reg.selected_method,
                       out_data_reg.dest_ipv4, out_data_reg.dest_port,
                       out_data_reg.address_kind, out_data_reg.command,
                       out_data_reg.version, out_data_reg.error_code};

endmodule

`default_nettype wire

### src/socks_request_parser.sv
// SOCKS request parser, top level: input register, parse state, step logic, result register.
// An accepted byte is registered at the input, then its result beat in the result register.
// Throughput: one byte per cycle unless m_tready stalls; one registered parse-state step.
// Reset: asynchronous, active low; clears parse state, both valid flags and sets
// max_string_length to 255.
// Depends on srp_pkg, srp_step, srp_out_stage and socks_request_parser_assert.svh.
`default_nettype none

module socks_request_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    // max_string_length
    input  logic [7:0]                 cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // data_byte[7:0]
    input  logic [srp_pkg::DataW-1:0]  s_tdata,
    // connection_start
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // error_code[2:0], version[5:3], command[13:6], address_kind[15:14],
    // dest_port[31:16], dest_ipv4[63:32], selected_method[71:64], name_byte[79:72]
    output logic [srp_pkg::TdataW-1:0] m_tdata,
    // event_res[2:0]
    output logic [srp_pkg::TuserW-1:0] m_tuser,
    // name_last
    output logic                       m_tlast
);
    import srp_pkg::*;

    logic              in_valid_reg;
    logic [DataW-1:0]  in_data_reg;
    logic              in_start_reg;
    logic [7:0]        max_len_reg;
    srp_state_t        state_reg;
    srp_state_t        state_next;
    srp_result_t       step_result;
    logic              advance;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    srp_step u_step (
        .state_cur         (state_reg),
        .data_byte         (in_data_reg),
        .connection_start  (in_start_reg),
        .max_string_length (max_len_reg),
        .state_next        (state_next),
        .result            (step_result)
    );

    srp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (step_result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`include "socks_request_parser_assert.svh"

    `SRP_ASSERT_HOLDS(a_no_overwrite, m_tvalid && !m_tready, !advance, "result beat overwritten")
    `SRP_ASSERT_NEXT(a_advance_shows, advance, m_tvalid, "advanced beat not presented")
    `SRP_ASSERT_HOLDS(a_last_is_name, m_tvalid && m_tlast, m_tuser == EV_NAME, "tlast off a name beat")
    `SRP_ASSERT_HOLDS(a_err_clear, m_tvalid && m_tuser != EV_ERROR && m_tuser != EV_METHOD, m_tdata[2:0] == ERR_NONE, "stray error code")
    `SRP_ASSERT_HOLDS(a_phase_known, 1'b1, state_reg.phase != PH_UNUSED, "unused phase reached")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for socks_request_parser: SOCKS4, SOCKS4a and SOCKS5 client byte
// streams, a byte-level parse predictor and a field-by-field check of every result beat.
// Depends on srp_pkg and the socks_request_parser RTL only.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srp_pkg::*;

    localparam int CycleLimit  = 1000000;
    localparam int PhaseBytes  = 250;
    localparam int HoldCycles  = 300;

    typedef struct {
        logic [7:0] value;
        logic       first;
    } client_byte_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [7:0]          cfg_wdata = 8'd0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DataW-1:0]    s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TdataW-1:0]   m_tdata;
    logic [TuserW-1:0]   m_tuser;
    logic                m_tlast;

    client_byte_t        client_bytes[$];
    logic [7:0]          conn_bytes[$];
    srp_result_t         expected_events[$];
    client_byte_t        next_byte;

    int                  mismatch_count = 0;
    int                  bytes_queued = 0;
    int                  beats_in = 0;
    int                  cycle_count = 0;
    int                  tx_gap = 0;
    int                  tx_steady = 0;
    int                  rx_wait = 0;
    int                  rx_steady = 0;
    int                  hold_left = 0;
    logic                hold_done = 1'b0;

    // parser state as predicted
    logic [7:0]          max_name_len = MAX_LEN_RESET;
    logic [3:0]          cur_phase;
    logic [2:0]          cur_ver;
    logic [7:0]          cur_cmd;
    logic [1:0]          cur_atyp;
    logic [15:0]         cur_port;
    logic [31:0]         cur_ipv4;
    logic [7:0]          cur_left;
    logic                method_seen;
    logic                authorised;

    socks_request_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void restart_connection();
        cur_phase   = PH_VER;
        cur_ver     = 3'd0;
        cur_cmd     = 8'd0;
        cur_atyp    = AT_NONE;
        cur_port    = 16'd0;
        cur_ipv4    = 32'd0;
        cur_left    = 8'd0;
        method_seen = 1'b0;
        authorised  = 1'b0;
    endfunction

    function automatic logic [2:0] finish_request(output logic [2:0] err);
        cur_phase = PH_HALT;
        err = ERR_NONE;
        if (cur_cmd != CMD_CONNECT)
        begin
            err = ERR_NOT_CONNECT;
            return EV_ERROR;
        end
        return EV_READY;
    endfunction

    function automatic logic name_too_long();
        if (cur_left >= max_name_len)
            return 1'b1;
        cur_left = cur_left + 8'd1;
        return 1'b0;
    endfunction

    function automatic srp_result_t parse_socks_byte(input logic [7:0] b, input logic start);
        srp_result_t r;
        logic [2:0]  pos;
        logic [2:0]  err;
        r = '0;
        r.event_res = EV_CONT;
        r.error_code = ERR_NONE;
        if (start)
            restart_connection();
        case (cur_phase)
            PH_VER:
            begin
                if (b == VER_SOCKS4)
                begin
                    cur_ver = 3'd4;
                    cur_left = 8'd7;
                    cur_phase = PH_S4_FIX;
                end
                else if (b == VER_SOCKS5)
                begin
                    cur_ver = 3'd5;
                    cur_phase = PH_S5_NMETH;
                end
                else
                begin
                    r.event_res = EV_ERROR;
                    r.error_code = ERR_BAD_VERSION;
                    cur_phase = PH_HALT;
                end
            end
            PH_S4_FIX:
            begin
                pos = 3'd7 - cur_left[2:0];
                if (pos == 3'd0)
                    cur_cmd = b;
                else if (pos <= 3'd2)
                    cur_port = {cur_port[7:0], b};
                else
                    cur_ipv4 = {cur_ipv4[23:0], b};
                cur_left = cur_left - 8'd1;
                if (cur_left == 8'd0)
                begin
                    cur_atyp = (cur_ipv4 != 32'd0 && cur_ipv4 <= 32'd255) ? AT_NAME : AT_IPV4;
                    cur_phase = PH_S4_USER;
                end
            end
            PH_S4_USER:
            begin
                if (b == 8'd0)
                begin
                    if (cur_atyp == AT_NAME)
                    begin
                        cur_left = 8'd0;
                        cur_phase = PH_S4_HOST;
                    end
                    else
                    begin
                        r.event_res = finish_request(err);
                        r.error_code = err;
                    end
                end
                else if (name_too_long())
                begin
                    r.event_res = EV_ERROR;
                    r.error_code = ERR_TOO_LONG;
                    cur_phase = PH_HALT;
                end
            end
            PH_S4_HOST:
            begin
                if (b == 8'd0)
                begin
                    r.event_res = finish_request(err);
                    r.error_code = err;
                end
                else if (name_too_long())
                begin
                    r.event_res = EV_ERROR;
                    r.error_code = ERR_TOO_LONG;
                    cur_phase = PH_HALT;
                end
                else
                begin
                    r.event_res = EV_NAME;
                    r.name_byte = b;
                end
            end
            PH_S5_NMETH:
            begin
                if (b == 8'd0)
                begin
                    r.event_res = EV_ERROR;
                    r.error_code = ERR_NO_METHODS;
                    cur_phase = PH_HALT;
                end
                else
                begin
                    cur_left = b;
                    method_seen = 1'b0;
                    cur_phase = PH_S5_METH;
                end
            end
            PH_S5_METH:
            begin
                if (b == METHOD_NOAUTH)
                    method_seen = 1'b1;
                cur_left = cur_left - 8'd1;
                if (cur_left == 8'd0)
                begin
                    r.event_res = EV_METHOD;
                    if (method_seen)
                    begin
                        authorised = 1'b1;
                        cur_phase = PH_S5_RVER;
                    end
                    else
                    begin
                        r.error_code = ERR_NO_ACCEPT;
                        cur_phase = PH_HALT;
                    end
                end
            end
            PH_S5_RVER:
                cur_phase = PH_S5_RCMD;
            PH_S5_RCMD:
            begin
                cur_cmd = b;
                cur_phase = PH_S5_RSV;
            end
            PH_S5_RSV:
                cur_phase = PH_S5_ATYP;
            PH_S5_ATYP:
            begin
                if (b == ATYP_IPV4)
                begin
                    cur_atyp = AT_IPV4;
                    cur_left = 8'd4;
                    cur_phase = PH_S5_IPV4;
                end
                else if (b == ATYP_DOMAIN)
                begin
                    cur_atyp = AT_NAME;
                    cur_phase = PH_S5_DLEN;
                end
                else if (b == ATYP_IPV6)
                begin
                    cur_atyp = AT_IPV6;
                    cur_left = 8'd16;
                    cur_phase = PH_S5_NAME;
                end
                else
                begin
                    r.event_res = EV_ERROR;
                    r.error_code = ERR_BAD_ATYP;
                    cur_phase = PH_HALT;
                end
            end
            PH_S5_IPV4:
            begin
                cur_ipv4 = {cur_ipv4[23:0], b};
                cur_left = cur_left - 8'd1;
                if (cur_left == 8'd0)
                begin
                    cur_left = 8'd2;
                    cur_phase = PH_S5_PORT;
                end
            end
            PH_S5_DLEN:
            begin
                if (b == 8'd0)
                begin
                    cur_left = 8'd2;
                    cur_phase = PH_S5_PORT;
                end
                else
                begin
                    cur_left = b;
                    cur_phase = PH_S5_NAME;
                end
            end
            PH_S5_NAME:
            begin
                r.event_res = EV_NAME;
                r.name_byte = b;
                cur_left = cur_left - 8'd1;
                if (cur_left == 8'd0)
                begin
                    r.name_last = 1'b1;
                    cur_left = 8'd2;
                    cur_phase = PH_S5_PORT;
                end
            end
            PH_S5_PORT:
            begin
                cur_port = {cur_port[7:0], b};
                cur_left = cur_left - 8'd1;
                if (cur_left == 8'd0)
                begin
                    r.event_res = finish_request(err);
                    r.error_code = err;
                end
            end
            default:
                cur_phase = PH_HALT;
        endcase
        r.version = cur_ver;
        r.command = cur_cmd;
        r.address_kind = cur_atyp;
        r.dest_port = cur_port;
        r.dest_ipv4 = cur_ipv4;
        r.selected_method = method_seen ? METHOD_NOAUTH : METHOD_NONE;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2 || (r < 10 && max_name_len <= 40))
            return int'(max_name_len) - 1 + $urandom_range(0, 2);
        return $urandom_range(0, 6);
    endfunction

    // push the built connection, cut to keep bytes; lead is the start flag of its first byte
    task automatic commit_connection(input int keep, input logic lead);
        client_byte_t cb;
        for (int i = 0; i < keep && i < conn_bytes.size(); i++)
        begin
            cb.value = conn_bytes[i];
            cb.first = (i == 0) ? lead : 1'b0;
            client_bytes.push_back(cb);
            bytes_queued++;
        end
    endtask

    task automatic build_socks4();
        logic [31:0] ip;
        logic [7:0]  cmd;
        logic [15:0] port;
        int          r;
        int          len;
        r = $urandom_range(0, 99);
        cmd = ($urandom_range(0, 9) < 8) ? CMD_CONNECT : 8'($urandom_range(0, 255));
        port = 16'($urandom);
        if (r < 35)
            ip = $urandom_range(1, 255);
        else if (r < 40)
            ip = $urandom_range(0, 1) ? 32'd255 : 32'd256;
        else if (r < 45)
            ip = 32'd0;
        else
            ip = $urandom;
        conn_bytes.push_back(VER_SOCKS4);
        conn_bytes.push_back(cmd);
        conn_bytes.push_back(port[15:8]);
        conn_bytes.push_back(port[7:0]);
        conn_bytes.push_back(ip[31:24]);
        conn_bytes.push_back(ip[23:16]);
        conn_bytes.push_back(ip[15:8]);
        conn_bytes.push_back(ip[7:0]);
        len = pick_len();
        for (int i = 0; i < len; i++)
            conn_bytes.push_back(8'($urandom_range(1, 255)));
        conn_bytes.push_back(8'd0);
        if (ip != 32'd0 && ip <= 32'd255)
        begin
            len = pick_len();
            for (int i = 0; i < len; i++)
                conn_bytes.push_back(8'($urandom_range(1, 255)));
            conn_bytes.push_back(8'd0);
        end
    endtask

    task automatic build_socks5();
        int          nm;
        int          pos;
        int          r;
        int          dlen;
        logic        acceptable;
        logic [7:0]  atyp;
        r = $urandom_range(0, 99);
        if (r < 3)
            nm = 0;
        else if (r < 7)
            nm = $urandom_range(5, 255);
        else
            nm = $urandom_range(1, 4);
        conn_bytes.push_back(VER_SOCKS5);
        conn_bytes.push_back(8'(nm));
        if (nm == 0)
            return;
        acceptable = ($urandom_range(0, 9) < 8);
        pos = $urandom_range(0, nm - 1);
        for (int i = 0; i < nm; i++)
            conn_bytes.push_back((acceptable && i == pos) ? METHOD_NOAUTH
                                                          : 8'($urandom_range(1, 255)));
        if (!acceptable)
            return;
        conn_bytes.push_back(($urandom_range(0, 3) != 0) ? VER_SOCKS5 : 8'($urandom));
        conn_bytes.push_back(($urandom_range(0, 9) < 8) ? CMD_CONNECT : 8'($urandom));
        conn_bytes.push_back(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 30)
            atyp = ATYP_IPV4;
        else if (r < 60)
            atyp = ATYP_DOMAIN;
        else if (r < 90)
            atyp = ATYP_IPV6;
        else
            atyp = 8'($urandom);
        conn_bytes.push_back(atyp);
        if (atyp == ATYP_IPV4)
        begin
            for (int i = 0; i < 4; i++)
                conn_bytes.push_back(8'($urandom));
        end
        else if (atyp == ATYP_DOMAIN)
        begin
            r = $urandom_range(0, 99);
            dlen = (r < 10) ? 0 : (r < 14) ? $urandom_range(9, 255) : $urandom_range(1, 8);
            conn_bytes.push_back(8'(dlen));
            for (int i = 0; i < dlen; i++)
                conn_bytes.push_back(8'($urandom));
        end
        else if (atyp == ATYP_IPV6)
        begin
            for (int i = 0; i < 16; i++)
                conn_bytes.push_back(8'($urandom));
        end
        else
            return;
        conn_bytes.push_back(8'($urandom));
        conn_bytes.push_back(8'($urandom));
    endtask

    task automatic run_random_phase(input int count);
        int target;
        int r;
        int keep;
        target = bytes_queued + count;
        while (bytes_queued < target)
        begin
            conn_bytes.delete();
            r = $urandom_range(0, 99);
            if (r < 45)
                build_socks5();
            else if (r < 80)
                build_socks4();
            else
            begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    conn_bytes.push_back(8'($urandom));
            end
            keep = conn_bytes.size();
            if ($urandom_range(0, 9) == 0)
                keep = $urandom_range(1, keep);
            commit_connection(keep, (r < 80) ? 1'b1 : 1'($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 4) == 0)
            begin
                conn_bytes.delete();
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    conn_bytes.push_back(8'($urandom));
                commit_connection(conn_bytes.size(), 1'b0);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (client_bytes.size() != 0 || s_tvalid || expected_events.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max_len(input logic [7:0] len);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_name_len = len;
    endtask

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatch_count++;
        end
    endfunction

    // sender: offer queued client bytes, predict each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
            tx_steady <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_events.push_back(parse_socks_byte(s_tdata, s_tuser));
                beats_in <= beats_in + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (client_bytes.size() > 0)
                begin
                    next_byte = client_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_byte.value;
                    s_tuser <= next_byte.first;
                    if (tx_steady > 0)
                        tx_steady <= tx_steady - 1;
                    else
                    begin
                        tx_gap <= pick_gap();
                        if ($urandom_range(0, 39) == 0)
                            tx_steady <= $urandom_range(20, 60);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // hold the receiver off once for a long stretch while bytes are still queued
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && beats_in >= 300 && client_bytes.size() > 40)
        begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait <= 0;
            rx_steady <= 0;
        end
        else if (hold_left > 0)
            m_tready <= 1'b0;
        else if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (rx_steady > 0)
                rx_steady <= rx_steady - 1;
            else
            begin
                rx_wait <= pick_gap();
                if ($urandom_range(0, 39) == 0)
                    rx_steady <= $urandom_range(20, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        srp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatch_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                check_field("event_res", want.event_res, m_tuser);
                check_field("error_code", want.error_code, m_tdata[2:0]);
                check_field("version", want.version, m_tdata[5:3]);
                check_field("command", want.command, m_tdata[13:6]);
                check_field("address_kind", want.address_kind, m_tdata[15:14]);
                check_field("dest_port", want.dest_port, m_tdata[31:16]);
                check_field("dest_ipv4", want.dest_ipv4, m_tdata[63:32]);
                check_field("selected_method", want.selected_method, m_tdata[71:64]);
                check_field("name_byte", want.name_byte, m_tdata[79:72]);
                check_field("name_last", want.name_last, m_tlast);
            end
        end
    end

    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        restart_connection();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // bad version on the very first byte without a start flag, then a halted byte
        conn_bytes = '{8'h07, 8'h00};
        commit_connection(2, 1'b0);
        // no methods offered
        conn_bytes = '{VER_SOCKS5, 8'h00};
        commit_connection(2, 1'b1);
        // no acceptable method
        conn_bytes = '{VER_SOCKS5, 8'h01, 8'h02};
        commit_connection(3, 1'b1);
        // unknown address type
        conn_bytes = '{VER_SOCKS5, 8'h01, METHOD_NOAUTH, VER_SOCKS5, 8'h02, 8'hFF, 8'hFF};
        commit_connection(7, 1'b1);
        run_random_phase(PhaseBytes);

        write_max_len(8'd1);
        // SOCKS4a user id one byte over the limit
        conn_bytes = '{VER_SOCKS4, CMD_CONNECT, 8'h00, 8'h50, 8'h00, 8'h00, 8'h00, 8'h07,
                       8'h61, 8'h62};
        commit_connection(10, 1'b1);
        run_random_phase(PhaseBytes);

        write_max_len(8'd2);
        run_random_phase(PhaseBytes);
        write_max_len(8'($urandom_range(3, 40)));
        run_random_phase(PhaseBytes);
        write_max_len(8'd255);
        run_random_phase(PhaseBytes);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

### socks_request_parser.f
+incdir+src
src/srp_pkg.sv
src/srp_step.sv
src/srp_out_stage.sv
src/socks_request_parser.sv
tb/sv/tb_top.sv
